>>> rtl/nsc_pkg.sv
`default_nettype none

package nsc_pkg;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_BODY  = 2'd1;
  localparam logic [1:0] PH_TAIL  = 2'd2;
  localparam logic [1:0] PH_BAD   = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic       checksum_ok;
    logic [7:0] computed_xor;
    logic [7:0] line_length;
  } out_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_newline;
    logic       is_dollar;
    logic       is_star;
    logic       is_last;
  } cls_item_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      return 8'h30 + wide;
    end else begin
      return 8'h37 + wide;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/nsc_front.sv
`default_nettype none

module nsc_front (
  input  wire nsc_pkg::in_item_t  in_item,
  output nsc_pkg::cls_item_t      cls_item
);

  always_comb begin
    cls_item.data_byte  = in_item.data_byte;
    cls_item.is_newline = (in_item.data_byte == nsc_pkg::CH_NEWLINE);
    cls_item.is_dollar  = (in_item.data_byte == nsc_pkg::CH_DOLLAR);
    cls_item.is_star    = (in_item.data_byte == nsc_pkg::CH_STAR);
    cls_item.is_last    = in_item.is_last;
  end

endmodule

`default_nettype wire

>>> rtl/nsc_queue.sv
`default_nettype none

module nsc_queue (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     wr_en,
  input  wire nsc_pkg::cls_item_t wr_item,
  output logic                    full,
  input  wire                     rd_en,
  output nsc_pkg::cls_item_t      rd_item,
  output logic                    empty
);

  localparam int PW = (nsc_pkg::QUEUE_DEPTH > 1) ? $clog2(nsc_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(nsc_pkg::QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(nsc_pkg::QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_C  = PW'(nsc_pkg::QUEUE_DEPTH - 1);

  nsc_pkg::cls_item_t slots [nsc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_C) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_C) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("queue count beyond depth");

  a_full_no_grow: assert property (@(posedge clk) disable iff (rst)
    (full && !rd_en) |=> full && (wr_ptr == $past(wr_ptr)))
    else $error("queue written while full");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == DEPTH_C) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> rtl/nsc_back.sv
`default_nettype none

module nsc_back #(
  parameter int MAX_LINE = 254
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire nsc_pkg::cls_item_t cls_item,
  input  wire                     cls_empty,
  output logic                    cls_take,
  output nsc_pkg::out_item_t      result,
  output logic                    empty,
  input  wire                     pop
);

  localparam int BW = $clog2(MAX_LINE + 1);
  localparam logic [BW-1:0] MAX_C = BW'(MAX_LINE);

  logic [1:0]    line_phase;
  logic [7:0]    xor_accumulator;
  logic [1:0]    tail_count;
  logic          tail_match;
  logic [BW-1:0] byte_count;
  logic          line_rejected;
  logic          out_valid;

  logic [1:0]    line_phase_next;
  logic [7:0]    xor_accumulator_next;
  logic [1:0]    tail_count_next;
  logic          tail_match_next;
  logic [BW-1:0] byte_count_next;
  logic          line_rejected_next;
  logic          close_line;
  logic          emit;
  logic [7:0]    expect_byte;

  assign empty    = !out_valid;
  assign cls_take = !cls_empty && (!out_valid || pop);

  always_comb begin
    line_phase_next      = line_phase;
    xor_accumulator_next = xor_accumulator;
    tail_count_next      = tail_count;
    tail_match_next      = tail_match;
    byte_count_next      = byte_count;
    line_rejected_next   = line_rejected;
    expect_byte          = (tail_count == 2'd0) ? nsc_pkg::hex_digit(xor_accumulator[7:4])
                                                : nsc_pkg::hex_digit(xor_accumulator[3:0]);
    if (!cls_item.is_newline) begin
      if (byte_count < MAX_C) begin
        byte_count_next = byte_count + 1'b1;
      end else begin
        line_rejected_next = 1'b1;
      end
      case (line_phase)
        nsc_pkg::PH_START: begin
          line_phase_next = cls_item.is_dollar ? nsc_pkg::PH_BODY : nsc_pkg::PH_BAD;
        end
        nsc_pkg::PH_BODY: begin
          if (cls_item.is_star) begin
            line_phase_next = nsc_pkg::PH_TAIL;
          end else begin
            xor_accumulator_next = xor_accumulator ^ cls_item.data_byte;
          end
        end
        nsc_pkg::PH_TAIL: begin
          if (tail_count[1] || (cls_item.data_byte != expect_byte)) begin
            tail_match_next = 1'b0;
          end
          if (tail_count != 2'd3) begin
            tail_count_next = tail_count + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    close_line = cls_item.is_newline || cls_item.is_last;
    emit = close_line && (line_phase_next == nsc_pkg::PH_TAIL) &&
           (tail_count_next == 2'd2) && !line_rejected_next;
  end

  always_ff @(posedge clk) begin
    if (cls_take && emit) begin
      result.checksum_ok  <= tail_match_next;
      result.computed_xor <= xor_accumulator_next;
      result.line_length  <= 8'(byte_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase      <= nsc_pkg::PH_START;
      xor_accumulator <= '0;
      tail_count      <= '0;
      tail_match      <= 1'b1;
      byte_count      <= '0;
      line_rejected   <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cls_take) begin
        if (close_line) begin
          line_phase      <= nsc_pkg::PH_START;
          xor_accumulator <= '0;
          tail_count      <= '0;
          tail_match      <= 1'b1;
          byte_count      <= '0;
          line_rejected   <= 1'b0;
        end else begin
          line_phase      <= line_phase_next;
          xor_accumulator <= xor_accumulator_next;
          tail_count      <= tail_count_next;
          tail_match      <= tail_match_next;
          byte_count      <= byte_count_next;
          line_rejected   <= line_rejected_next;
        end
      end
      if (cls_take && emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_reject_at_cap: assert property (@(posedge clk) disable iff (rst)
    line_rejected |-> (byte_count == MAX_C))
    else $error("line rejected below the length cap");

  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    (line_phase == nsc_pkg::PH_START) |-> (byte_count == '0) && (xor_accumulator == '0))
    else $error("line state not cleared at line start");

  a_tail_phase: assert property (@(posedge clk) disable iff (rst)
    (tail_count != 2'd0) |-> (line_phase == nsc_pkg::PH_TAIL))
    else $error("tail bytes counted outside the tail");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |-> !cls_take)
    else $error("queue drained while result is held");

endmodule

`default_nettype wire

>>> rtl/nmea_sentence_checksum_check.sv
`default_nettype none
// Channel   Handshake          Payload
// input     push / full        in_item  (data_byte, is_last)
// result    empty / pop        result   (checksum_ok, computed_xor, line_length)
//
// One byte is taken per cycle while full is low; back-end line state updates once per byte.
// A result is registered when the back end takes the byte closing a qualifying line.
// A two-entry queue sits between byte classification and line state; the result
// register frees in the cycle it is popped, so the back end keeps moving.
// Reset (rst, synchronous) empties the queue and clears the line state.
module nmea_sentence_checksum_check #(
  parameter int MAX_LINE = 254
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  output logic                    full,
  input  wire nsc_pkg::in_item_t  in_item,
  output logic                    empty,
  input  wire                     pop,
  output nsc_pkg::out_item_t      result
);

  nsc_pkg::cls_item_t cls_in;
  nsc_pkg::cls_item_t cls_out;
  logic               q_empty;
  logic               q_take;

  nsc_front u_front (
    .in_item  (in_item),
    .cls_item (cls_in)
  );

  nsc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_item (cls_in),
    .full    (full),
    .rd_en   (q_take),
    .rd_item (cls_out),
    .empty   (q_empty)
  );

  nsc_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_item  (cls_out),
    .cls_empty (q_empty),
    .cls_take  (q_take),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int LINE_MAX = 254;
  localparam int ITEM_TARGET = 1150;
  localparam int CALM_TAIL = 150;
  localparam int LONG_HOLD = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum int {
    KIND_GOOD, KIND_BADSUM, KIND_CR, KIND_SHORT, KIND_LONG, KIND_NOSTAR, KIND_NOSTART
  } line_kind_e;

  typedef enum int {END_NEWLINE, END_LAST, END_LAST_NEWLINE} line_end_e;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  nsc_pkg::in_item_t  in_item = '0;
  logic               full;
  logic               empty;
  nsc_pkg::out_item_t result;

  nmea_sentence_checksum_check #(.MAX_LINE(LINE_MAX)) dut (
    .clk, .rst, .push, .full, .in_item, .empty, .pop, .result
  );

  nsc_pkg::in_item_t  pending[$];
  nsc_pkg::out_item_t verdict_q[$];
  nsc_pkg::out_item_t want;

  int   taken_count = 0;
  int   stim_total = 0;
  int   results_seen = 0;
  int   errors = 0;
  int   quiet_cycles = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  logic long_hold = 1'b0;

  logic [1:0] ln_phase = nsc_pkg::PH_START;
  logic [7:0] ln_xor = '0;
  int         ln_tail = 0;
  logic       ln_match = 1'b1;
  int         ln_len = 0;
  logic       ln_over = 1'b0;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
  endfunction

  function automatic void end_line();
    nsc_pkg::out_item_t v;
    if (ln_phase == nsc_pkg::PH_TAIL && ln_tail == 2 && !ln_over) begin
      v.checksum_ok = ln_match;
      v.computed_xor = ln_xor;
      v.line_length = ln_len[7:0];
      verdict_q.push_back(v);
    end
    ln_phase = nsc_pkg::PH_START;
    ln_xor = '0;
    ln_tail = 0;
    ln_match = 1'b1;
    ln_len = 0;
    ln_over = 1'b0;
  endfunction

  function automatic void track_byte(input nsc_pkg::in_item_t it);
    logic [7:0] b;
    b = it.data_byte;
    if (b == nsc_pkg::CH_NEWLINE) begin
      end_line();
    end else begin
      if (ln_len < LINE_MAX) ln_len++;
      else ln_over = 1'b1;
      case (ln_phase)
        nsc_pkg::PH_START: begin
          ln_phase = (b == nsc_pkg::CH_DOLLAR) ? nsc_pkg::PH_BODY : nsc_pkg::PH_BAD;
        end
        nsc_pkg::PH_BODY: begin
          if (b == nsc_pkg::CH_STAR) ln_phase = nsc_pkg::PH_TAIL;
          else ln_xor ^= b;
        end
        nsc_pkg::PH_TAIL: begin
          if (ln_tail == 0) begin
            if (b != hex_char(ln_xor[7:4])) ln_match = 1'b0;
          end else if (ln_tail == 1) begin
            if (b != hex_char(ln_xor[3:0])) ln_match = 1'b0;
          end else begin
            ln_match = 1'b0;
          end
          if (ln_tail < 3) ln_tail++;
        end
        default: ;
      endcase
      if (it.is_last) end_line();
    end
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic last);
    nsc_pkg::in_item_t it;
    it.data_byte = b;
    it.is_last = last;
    pending.push_back(it);
  endtask

  function automatic logic [7:0] body_char();
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 2) == 0) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(8'h20, 8'h7E));
    end while (b == nsc_pkg::CH_STAR || b == nsc_pkg::CH_NEWLINE);
    return b;
  endfunction

  task automatic add_sentence(input line_kind_e kind, input int body_len, input line_end_e fin);
    logic [7:0] ln[$];
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] hi;
    logic [7:0] lo;
    sum = '0;
    if (kind == KIND_NOSTART) begin
      do b = 8'($urandom_range(0, 255));
      while (b == nsc_pkg::CH_DOLLAR || b == nsc_pkg::CH_NEWLINE);
      ln.push_back(b);
    end else begin
      ln.push_back(nsc_pkg::CH_DOLLAR);
    end
    repeat (body_len) begin
      b = body_char();
      sum ^= b;
      ln.push_back(b);
    end
    hi = hex_char(sum[7:4]);
    lo = hex_char(sum[3:0]);
    if (kind != KIND_NOSTAR) ln.push_back(nsc_pkg::CH_STAR);
    case (kind)
      KIND_GOOD, KIND_NOSTART: begin
        ln.push_back(hi);
        ln.push_back(lo);
      end
      KIND_BADSUM: begin
        case ($urandom_range(0, 2))
          0: begin
            ln.push_back(hi | 8'h20);
            ln.push_back(lo | 8'h20);
          end
          1: begin
            ln.push_back(lo);
            ln.push_back(hi);
          end
          default: begin
            ln.push_back(body_char());
            ln.push_back(body_char());
          end
        endcase
      end
      KIND_CR: begin
        ln.push_back(hi);
        if ($urandom_range(0, 1) == 1) ln.push_back(lo);
        ln.push_back(CH_CR);
      end
      KIND_SHORT: begin
        if ($urandom_range(0, 1) == 1) ln.push_back(hi);
      end
      KIND_LONG: begin
        ln.push_back(hi);
        ln.push_back(lo);
        repeat ($urandom_range(1, 2)) ln.push_back(body_char());
      end
      default: ;
    endcase
    foreach (ln[i]) add_byte(ln[i], fin == END_LAST && i == ln.size() - 1);
    if (fin != END_LAST) add_byte(nsc_pkg::CH_NEWLINE, fin == END_LAST_NEWLINE);
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    int         pick;
    int         blen;
    bit         long_done;
    line_kind_e kind;
    line_end_e  fin;
    long_done = 1'b0;

    add_byte(nsc_pkg::CH_NEWLINE, 1'b0);
    add_byte(nsc_pkg::CH_DOLLAR, 1'b0);
    add_byte(nsc_pkg::CH_STAR, 1'b0);
    add_byte("0", 1'b0);
    add_byte("0", 1'b0);
    add_byte(nsc_pkg::CH_NEWLINE, 1'b0);
    add_byte(nsc_pkg::CH_DOLLAR, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(nsc_pkg::CH_DOLLAR, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(nsc_pkg::CH_STAR, 1'b0);
    add_byte("D", 1'b0);
    add_byte("B", 1'b1);
    add_byte(nsc_pkg::CH_DOLLAR, 1'b0);
    add_byte("A", 1'b0);
    add_byte(nsc_pkg::CH_STAR, 1'b0);
    add_byte("4", 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(nsc_pkg::CH_NEWLINE, 1'b0);
    add_byte(nsc_pkg::CH_DOLLAR, 1'b0);
    add_byte("A", 1'b0);
    add_byte(nsc_pkg::CH_STAR, 1'b0);
    add_byte(nsc_pkg::CH_STAR, 1'b0);
    add_byte("1", 1'b0);
    add_byte(nsc_pkg::CH_NEWLINE, 1'b1);

    while (pending.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (!long_done && pending.size() > 350) begin
        // close any open line, then one line at the length limit and one just past it
        add_byte(nsc_pkg::CH_NEWLINE, 1'b0);
        add_sentence(KIND_GOOD, LINE_MAX - 4, END_NEWLINE);
        add_sentence(KIND_GOOD, LINE_MAX - 3, END_NEWLINE);
        long_done = 1'b1;
      end else if (pick < 8) begin
        repeat ($urandom_range(1, 12))
          add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
      end else begin
        kind = (pick < 50) ? KIND_GOOD :
               (pick < 62) ? KIND_BADSUM :
               (pick < 70) ? KIND_CR :
               (pick < 78) ? KIND_SHORT :
               (pick < 85) ? KIND_LONG :
               (pick < 92) ? KIND_NOSTAR : KIND_NOSTART;
        blen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        pick = $urandom_range(0, 99);
        fin = (pick < 75) ? END_NEWLINE : (pick < 93) ? END_LAST : END_LAST_NEWLINE;
        add_sentence(kind, blen, fin);
      end
    end
    stim_total = pending.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (taken_count != stim_total) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("nmea_sentence_checksum_check test passed");
    end else begin
      $display("nmea_sentence_checksum_check test failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      gap_left = 0;
    end else begin
      if (push && !full) begin
        track_byte(in_item);
        taken_count++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending.size() == 0) begin
          push <= 1'b0;
        end else if (!long_hold && pending.size() >= CALM_TAIL &&
                     $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 12);
          push <= 1'b0;
        end else begin
          push <= 1'b1;
          in_item <= pending.pop_front();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, got %h", $time, result);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          results_seen++;
          if (result.checksum_ok !== want.checksum_ok) begin
            $display("%0t: checksum_ok expected %0d got %0d", $time,
                     want.checksum_ok, result.checksum_ok);
            errors++;
          end
          if (result.computed_xor !== want.computed_xor) begin
            $display("%0t: computed_xor expected %h got %h", $time,
                     want.computed_xor, result.computed_xor);
            errors++;
          end
          if (result.line_length !== want.line_length) begin
            $display("%0t: line_length expected %0d got %0d", $time,
                     want.line_length, result.line_length);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
        if (hold_left == 0) long_hold <= 1'b0;
      end else if (!hold_done && results_seen == 10) begin
        // hold off long enough for the block to fill and stall its input
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
        long_hold <= 1'b1;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (pending.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("nmea_sentence_checksum_check test failed");
    $finish;
  end

endmodule
